>>> rtl/hcid_pkg.sv
// Shared types and constants for the HCI H4 UART packet deframer.
`default_nettype none

package hcid_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_RESET = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    // Result status carried on the output tuser
    typedef enum logic [3:0] {
        ST_WAIT       = 4'd0,
        ST_DONE       = 4'd1,
        ST_NO_CARRIER = 4'd2,
        ST_LINE_ERR   = 4'd3,
        ST_OVERFLOW   = 4'd4,
        ST_UNKNOWN    = 4'd5,
        ST_TOO_BIG    = 4'd6,
        ST_READ       = 4'd7,
        ST_REQ_DONE   = 4'd8
    } status_t;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IND  = 2'd0,
        PH_HDR  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // H4 packet indicators
    localparam logic [7:0] TYPE_ACL = 8'h02;
    localparam logic [7:0] TYPE_SCO = 8'h03;
    localparam logic [7:0] TYPE_EVT = 8'h04;

    // Header sizes including the indicator byte
    localparam int HDR_BYTES_ACL = 5;
    localparam int HDR_BYTES_SCO = 4;
    localparam int HDR_BYTES_EVT = 3;

    // Buffer index of the low length byte of an ACL header
    localparam int ACL_LEN_LO_IDX = 3;

    // Per-request result, less the buffer read data
    typedef struct packed {
        status_t     status;
        logic [7:0]  packet_type;
        logic [9:0]  packet_length;
        logic        delivered;
        logic        read_sel;
    } result_t;

    // Running statistics
    typedef struct packed {
        logic [31:0] error_count;
        logic [31:0] byte_count;
        logic [31:0] packet_count;
    } stats_t;

endpackage

`default_nettype wire

>>> rtl/hci_uart_packet_deframer.sv
// Top level of the HCI H4 UART packet deframer.
`default_nettype none

// Frames HCI H4 packets (ACL, SCO, event) out of received UART bytes and
// answers buffer reads, parser resets and statistics clears. Every request
// gives exactly one result. A request is taken whenever the output register is
// free or being read, and its result appears there in the next cycle; the rate,
// one request per cycle while the output does not stall, is set by the packet
// buffer's single write port and single registered read port, which each serve
// at most one request a cycle. The buffer needs no clearing pass after reset;
// reading a never-received byte gives an unspecified value. deliver_enable is
// written through cfg_wr_en and should only change while no request is outstanding.
module hci_uart_packet_deframer #(
    parameter int BUF_BYTES = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // configuration
    input  wire logic          cfg_wr_en,
    input  wire logic          cfg_wr_data,    // deliver_enable
    // request channel
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [1:0]    s_tuser,        // req_type
    input  wire logic [23:0]   s_tdata,        // rx_byte, line_error, carrier_present,
                                               // read_index, zero fill
    // result channel
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [3:0]    m_tuser,        // status
    output logic      [127:0]  m_tdata         // packet_type, packet_length, delivered,
                                               // read_data, error_count, byte_count,
                                               // packet_count, zero fill
);

    import hcid_pkg::*;

    localparam int AW = $clog2(BUF_BYTES);
    localparam int CW = $clog2(BUF_BYTES + 1);

    logic          deliver_en_reg;
    logic          m_valid_reg;
    result_t       res_reg;
    result_t       result;
    stats_t        stats;
    logic          accept;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;
    logic [7:0]    read_data;

    // handshake: take a request whenever the output register frees up
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    hcid_parser #(
        .BUF_BYTES (BUF_BYTES),
        .AW        (AW),
        .CW        (CW)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .req             (req_t'(s_tuser)),
        .rx_byte         (s_tdata[7:0]),
        .line_error      (s_tdata[8]),
        .carrier_present (s_tdata[9]),
        .read_index      (s_tdata[19:10]),
        .deliver_enable  (deliver_en_reg),
        .result          (result),
        .stats           (stats),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr)
    );

    hcid_buf_mem #(
        .BUF_BYTES (BUF_BYTES),
        .AW        (AW)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deliver_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            deliver_en_reg <= cfg_wr_data;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload; stats registers already hold the post-request values
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= result;
        end
    end

    assign read_data = res_reg.read_sel ? mem_rd_data : 8'h00;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {5'd0,
                       stats.packet_count,
                       stats.byte_count,
                       stats.error_count,
                       read_data,
                       res_reg.delivered,
                       res_reg.packet_length,
                       res_reg.packet_type};

endmodule

`default_nettype wire

>>> rtl/hcid_buf_mem.sv
// Packet byte buffer: one write port and one registered read port.
`default_nettype none

module hcid_buf_mem #(
    parameter int BUF_BYTES = 1024,
    parameter int AW        = $clog2(BUF_BYTES)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [BUF_BYTES];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/hcid_parser.sv
// H4 framing state, statistics counters and buffer access control.
`default_nettype none

module hcid_parser #(
    parameter int BUF_BYTES = 1024,
    parameter int AW        = $clog2(BUF_BYTES),
    parameter int CW        = $clog2(BUF_BYTES + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire hcid_pkg::req_t    req,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              line_error,
    input  wire logic              carrier_present,
    input  wire logic [9:0]        read_index,
    input  wire logic              deliver_enable,
    output hcid_pkg::result_t      result,
    output hcid_pkg::stats_t       stats,
    output logic                   mem_wr_en,
    output logic      [AW-1:0]     mem_wr_addr,
    output logic      [7:0]        mem_wr_data,
    output logic                   mem_rd_en,
    output logic      [AW-1:0]     mem_rd_addr
);

    import hcid_pkg::*;

    phase_t        phase_reg, phase_next;
    logic [CW-1:0] wanted_reg, wanted_next;
    logic [CW-1:0] held_reg, held_next;
    logic [7:0]    type_reg;
    logic [7:0]    len_lo_reg;
    logic [31:0]   err_reg, err_next;
    logic [31:0]   bytes_reg, bytes_next;
    logic [31:0]   pkts_reg, pkts_next;

    logic [CW-1:0] held_inc;
    logic [7:0]    cur_type;
    logic [7:0]    byte_type;
    logic [15:0]   hdr_len;
    logic [31:0]   wanted_sum;
    logic [CW-1:0] hdr_wanted;
    logic          known_type;
    logic          byte_ok;
    logic          buf_full;
    logic          byte_stored;
    logic          read_in_range;
    status_t       status;

    // decode the request against the current parser state
    always_comb begin
        held_inc      = held_reg + CW'(1);
        cur_type      = (held_reg != '0) ? type_reg : 8'h00;
        byte_type     = (held_reg == '0) ? rx_byte : type_reg;
        byte_ok       = carrier_present && !line_error;
        buf_full      = 32'(held_reg) >= 32'(BUF_BYTES);
        byte_stored   = (req == REQ_BYTE) && byte_ok && !buf_full;
        read_in_range = {22'd0, read_index} < 32'(BUF_BYTES);
        known_type    = 1'b1;
        hdr_wanted    = CW'(1);
        hdr_len       = 16'h0000;
        case (byte_type)
            TYPE_ACL: begin
                hdr_wanted = CW'(HDR_BYTES_ACL);
                hdr_len    = {rx_byte, len_lo_reg};
            end
            TYPE_SCO: begin
                hdr_wanted = CW'(HDR_BYTES_SCO);
                hdr_len    = {8'h00, rx_byte};
            end
            TYPE_EVT: begin
                hdr_wanted = CW'(HDR_BYTES_EVT);
                hdr_len    = {8'h00, rx_byte};
            end
            default: begin
                known_type = 1'b0;
            end
        endcase
        wanted_sum = 32'(wanted_reg) + 32'(hdr_len);

        status = ST_WAIT;
        case (req)
            REQ_BYTE: begin
                if (!carrier_present) begin
                    status = ST_NO_CARRIER;
                end else if (line_error) begin
                    status = ST_LINE_ERR;
                end else if (buf_full) begin
                    status = ST_OVERFLOW;
                end else if (held_inc < wanted_reg) begin
                    status = ST_WAIT;
                end else begin
                    case (phase_reg)
                        PH_HDR: begin
                            if (hdr_len == 16'h0000) begin
                                status = ST_DONE;
                            end else if (wanted_sum >= 32'(BUF_BYTES)) begin
                                status = ST_TOO_BIG;
                            end else begin
                                status = ST_WAIT;
                            end
                        end
                        PH_DATA: begin
                            status = ST_DONE;
                        end
                        default: begin
                            status = known_type ? ST_WAIT : ST_UNKNOWN;
                        end
                    endcase
                end
            end
            REQ_READ: begin
                status = ST_READ;
            end
            default: begin
                status = ST_REQ_DONE;
            end
        endcase
    end

    // next parser state
    always_comb begin
        phase_next  = phase_reg;
        wanted_next = wanted_reg;
        held_next   = held_reg;
        if (accept) begin
            case (status)
                ST_WAIT: begin
                    held_next = held_inc;
                    if (held_inc >= wanted_reg) begin
                        if (phase_reg == PH_HDR) begin
                            wanted_next = wanted_sum[CW-1:0];
                            phase_next  = PH_DATA;
                        end else begin
                            wanted_next = hdr_wanted;
                            phase_next  = PH_HDR;
                        end
                    end
                end
                ST_NO_CARRIER, ST_LINE_ERR, ST_OVERFLOW, ST_UNKNOWN,
                ST_TOO_BIG, ST_DONE: begin
                    phase_next  = PH_IND;
                    wanted_next = CW'(1);
                    held_next   = '0;
                end
                ST_REQ_DONE: begin
                    if (req == REQ_RESET) begin
                        phase_next  = PH_IND;
                        wanted_next = CW'(1);
                        held_next   = '0;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // statistics
    always_comb begin
        err_next   = err_reg;
        bytes_next = bytes_reg;
        pkts_next  = pkts_reg;
        if (accept) begin
            if (req == REQ_CLEAR) begin
                err_next   = 32'd0;
                bytes_next = 32'd0;
                pkts_next  = 32'd0;
            end else begin
                if (status inside {ST_LINE_ERR, ST_OVERFLOW, ST_UNKNOWN, ST_TOO_BIG}) begin
                    err_next = err_reg + 32'd1;
                end
                if ((req == REQ_BYTE) && byte_ok) begin
                    bytes_next = bytes_reg + 32'd1;
                end
                if (status == ST_DONE) begin
                    pkts_next = pkts_reg + 32'd1;
                end
            end
        end
    end

    // result fields and buffer port control
    always_comb begin
        result.status        = status;
        result.packet_type   = byte_stored ? byte_type : cur_type;
        result.packet_length = (status == ST_DONE) ? 10'(32'(held_inc)) : 10'd0;
        result.delivered     = (status == ST_DONE) && deliver_enable;
        result.read_sel      = (req == REQ_READ) && read_in_range;
        stats.error_count    = err_reg;
        stats.byte_count     = bytes_reg;
        stats.packet_count   = pkts_reg;
        mem_wr_en            = accept && byte_stored;
        mem_wr_addr          = held_reg[AW-1:0];
        mem_wr_data          = rx_byte;
        mem_rd_en            = accept && (req == REQ_READ) && read_in_range;
        mem_rd_addr          = AW'(read_index);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IND;
            wanted_reg <= CW'(1);
            held_reg   <= '0;
            err_reg    <= 32'd0;
            bytes_reg  <= 32'd0;
            pkts_reg   <= 32'd0;
        end else begin
            phase_reg  <= phase_next;
            wanted_reg <= wanted_next;
            held_reg   <= held_next;
            err_reg    <= err_next;
            bytes_reg  <= bytes_next;
            pkts_reg   <= pkts_next;
        end
    end

    // shadow copies of the indicator and ACL low length byte
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            if (held_reg == '0) begin
                type_reg <= rx_byte;
            end
            if (held_reg == CW'(ACL_LEN_LO_IDX)) begin
                len_lo_reg <= rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the HCI H4 UART packet deframer.
`timescale 1ns / 1ps

module testbench;
    import hcid_pkg::*;

    localparam int BUF_BYTES = 1024;

    // One expected or observed result, unpacked
    typedef struct packed {
        status_t     status;
        logic [7:0]  ptype;
        logic [9:0]  plen;
        logic        dlv;
        logic [7:0]  rdata;
        logic [31:0] errs;
        logic [31:0] bytes;
        logic [31:0] pkts;
    } frame_result_t;

    // Directed stimulus row; st is checked as typed when typed is set
    typedef struct packed {
        req_t        req;
        logic [7:0]  rx;
        logic        lerr;
        logic        car;
        logic [9:0]  ridx;
        logic        typed;
        status_t     st;
    } dir_row_t;

    logic          aclk;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic          cfg_wr_data = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [1:0]    s_tuser = '0;
    logic [23:0]   s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [3:0]    m_tuser;
    logic [127:0]  m_tdata;

    // Predictor state
    phase_t        parse_ph;
    logic [10:0]   want;
    logic [10:0]   held;
    logic [7:0]    pbuf [0:BUF_BYTES-1];
    logic [31:0]   err_cnt;
    logic [31:0]   byte_cnt;
    logic [31:0]   pkt_cnt;
    logic          deliver_en;
    int            hi_water;      // entries [0, hi_water) have been written

    frame_result_t frame_q [$];
    dir_row_t      dir_rows [$];
    int            bad_results = 0;
    int            req_sent = 0;
    bit            src_quiet = 1'b0;
    bit            sink_quiet = 1'b0;
    int            stall_left = 0;

    hci_uart_packet_deframer #(
        .BUF_BYTES(BUF_BYTES)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAIL hci_uart_packet_deframer");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Back to hunting for an indicator byte
    function automatic void resync();
        parse_ph = PH_IND;
        want = 11'd1;
        held = 11'd0;
    endfunction

    // Predict the result of one request and advance the parser state
    function automatic frame_result_t deframe_step(req_t req, logic [7:0] rx, logic lerr,
                                                   logic car, logic [9:0] ridx);
        frame_result_t r;
        logic [7:0]    kind;
        int            len;
        int            total;
        bit            done;
        r = '0;
        r.status = ST_WAIT;
        r.ptype = (held != 0) ? pbuf[0] : 8'h00;
        done = 1'b0;
        case (req)
            REQ_BYTE: begin
                if (!car) begin
                    resync();
                    r.status = ST_NO_CARRIER;
                end else if (lerr) begin
                    err_cnt++;
                    resync();
                    r.status = ST_LINE_ERR;
                end else begin
                    byte_cnt++;
                    if (held >= BUF_BYTES) begin
                        err_cnt++;
                        resync();
                        r.status = ST_OVERFLOW;
                    end else begin
                        pbuf[held[9:0]] = rx;
                        held++;
                        if (int'(held) > hi_water) hi_water = int'(held);
                        kind = pbuf[0];
                        r.ptype = kind;
                        if (held < want) begin
                            r.status = ST_WAIT;
                        end else if (parse_ph == PH_HDR) begin
                            // header complete: pick up the payload length
                            len = 0;
                            if (kind == TYPE_ACL) len = int'({pbuf[4], pbuf[3]});
                            else if (kind == TYPE_SCO) len = int'(pbuf[3]);
                            else if (kind == TYPE_EVT) len = int'(pbuf[2]);
                            if (len == 0) begin
                                done = 1'b1;
                            end else begin
                                total = int'(want) + len;
                                if (total >= BUF_BYTES) begin
                                    err_cnt++;
                                    resync();
                                    r.status = ST_TOO_BIG;
                                end else begin
                                    want = 11'(total);
                                    parse_ph = PH_DATA;
                                end
                            end
                        end else if (parse_ph != PH_DATA) begin
                            // indicator byte selects the header size
                            if (kind == TYPE_ACL) want = 11'(HDR_BYTES_ACL);
                            else if (kind == TYPE_SCO) want = 11'(HDR_BYTES_SCO);
                            else if (kind == TYPE_EVT) want = 11'(HDR_BYTES_EVT);
                            if (kind == TYPE_ACL || kind == TYPE_SCO || kind == TYPE_EVT) begin
                                parse_ph = PH_HDR;
                            end else begin
                                err_cnt++;
                                resync();
                                r.status = ST_UNKNOWN;
                            end
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
            end
            REQ_READ: begin
                r.rdata = (ridx < BUF_BYTES) ? pbuf[ridx] : 8'h00;
                r.status = ST_READ;
            end
            REQ_RESET: begin
                resync();
                r.status = ST_REQ_DONE;
            end
            default: begin
                err_cnt = '0;
                byte_cnt = '0;
                pkt_cnt = '0;
                r.status = ST_REQ_DONE;
            end
        endcase
        if (done) begin
            r.status = ST_DONE;
            r.plen = held[9:0];
            r.dlv = deliver_en;
            pkt_cnt++;
            resync();
        end
        r.errs = err_cnt;
        r.bytes = byte_cnt;
        r.pkts = pkt_cnt;
        return r;
    endfunction

    function automatic string show(frame_result_t f);
        return $sformatf("st=%0d type=%h len=%0d dlv=%0b rd=%h err=%0d bytes=%0d pkts=%0d",
                         f.status, f.ptype, f.plen, f.dlv, f.rdata, f.errs, f.bytes, f.pkts);
    endfunction

    // Present one request, wait for its handshake, queue its expected result
    task automatic send_req(req_t req, logic [7:0] rx, logic lerr, logic car,
                            logic [9:0] ridx, bit typed, status_t typed_st);
        int            gap;
        frame_result_t expd;
        gap = src_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {4'b0, ridx, car, lerr, rx};
        do @(posedge aclk); while (!s_tready);
        expd = deframe_step(req, rx, lerr, car, ridx);
        if (typed) expd.status = typed_st;
        frame_q.push_back(expd);
        req_sent++;
    endtask

    // Received byte, with an occasional dropped carrier or line error unless clean
    task automatic send_rx(logic [7:0] b, bit clean);
        logic car;
        logic lerr;
        car = 1'b1;
        lerr = 1'b0;
        if (!clean && $urandom_range(0, 199) == 0) car = 1'b0;
        if (!clean && $urandom_range(0, 199) == 0) lerr = 1'b1;
        send_req(REQ_BYTE, b, lerr, car, 10'($urandom_range(0, 1023)), 1'b0, ST_WAIT);
    endtask

    // Indicator, random header content with the given length, then the payload
    task automatic send_packet(logic [7:0] kind, int len, bit clean);
        int i;
        send_rx(kind, clean);
        if (kind == TYPE_ACL) begin
            send_rx(8'($urandom_range(0, 255)), clean);
            send_rx(8'($urandom_range(0, 255)), clean);
            send_rx(len[7:0], clean);
            send_rx(len[15:8], clean);
        end else if (kind == TYPE_SCO) begin
            send_rx(8'($urandom_range(0, 255)), clean);
            send_rx(8'($urandom_range(0, 255)), clean);
            send_rx(len[7:0], clean);
        end else begin
            send_rx(8'($urandom_range(0, 255)), clean);
            send_rx(len[7:0], clean);
        end
        // an oversized packet is dropped at its header
        if (HDR_BYTES_ACL + len < BUF_BYTES) begin
            for (i = 0; i < len; i++) send_rx(8'($urandom_range(0, 255)), clean);
        end
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result check and receiver stalls
    always @(posedge aclk) begin : result_check
        frame_result_t seen;
        frame_result_t expd;
        if (aresetn && m_tvalid && m_tready) begin
            seen.status = status_t'(m_tuser);
            seen.ptype  = m_tdata[7:0];
            seen.plen   = m_tdata[17:8];
            seen.dlv    = m_tdata[18];
            seen.rdata  = m_tdata[26:19];
            seen.errs   = m_tdata[58:27];
            seen.bytes  = m_tdata[90:59];
            seen.pkts   = m_tdata[122:91];
            if (frame_q.size() == 0) begin
                bad_results++;
                if (bad_results <= 10) $display("unexpected result: %s", show(seen));
            end else begin
                expd = frame_q.pop_front();
                if (seen.status !== expd.status || seen.ptype !== expd.ptype ||
                    seen.plen !== expd.plen || seen.dlv !== expd.dlv ||
                    seen.rdata !== expd.rdata || seen.errs !== expd.errs ||
                    seen.bytes !== expd.bytes || seen.pkts !== expd.pkts) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", show(expd));
                        $display("  actual   %s", show(seen));
                    end
                end
            end
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            stall_left <= sink_quiet ? 0 : pick_gap();
        end
    end

    // Main sequence
    initial begin : stimulus
        int ph;
        int mark;
        int r;
        int k;
        logic [7:0] kind;

        resync();
        err_cnt = '0;
        byte_cnt = '0;
        pkt_cnt = '0;
        deliver_en = 1'b0;
        hi_water = 0;

        dir_rows = '{
            // ACL with two payload bytes
            '{REQ_BYTE,  8'h02, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'hFF, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h00, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h02, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h00, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'hAA, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h55, 1'b0, 1'b1, 10'd0, 1'b1, ST_DONE},
            '{REQ_READ,  8'h00, 1'b0, 1'b1, 10'd0, 1'b1, ST_READ},
            // event with empty payload completes at its header
            '{REQ_BYTE,  8'h04, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h0E, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h00, 1'b0, 1'b1, 10'd0, 1'b1, ST_DONE},
            // SCO with empty payload
            '{REQ_BYTE,  8'h03, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h80, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h00, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h00, 1'b0, 1'b1, 10'd0, 1'b1, ST_DONE},
            // unknown indicator
            '{REQ_BYTE,  8'hFF, 1'b0, 1'b1, 10'd0, 1'b1, ST_UNKNOWN},
            // carrier lost mid header
            '{REQ_BYTE,  8'h03, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h7E, 1'b0, 1'b0, 10'd0, 1'b1, ST_NO_CARRIER},
            // line error while idle
            '{REQ_BYTE,  8'h00, 1'b1, 1'b1, 10'd0, 1'b1, ST_LINE_ERR},
            // parser reset mid packet
            '{REQ_BYTE,  8'h02, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_RESET, 8'h00, 1'b0, 1'b1, 10'd0, 1'b1, ST_REQ_DONE},
            // ACL with maximum length field is too big
            '{REQ_BYTE,  8'h02, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h01, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'h00, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'hFF, 1'b0, 1'b1, 10'd0, 1'b0, ST_WAIT},
            '{REQ_BYTE,  8'hFF, 1'b0, 1'b1, 10'd0, 1'b1, ST_TOO_BIG},
            '{REQ_READ,  8'h00, 1'b0, 1'b1, 10'd4, 1'b1, ST_READ},
            '{REQ_CLEAR, 8'h00, 1'b0, 1'b1, 10'd0, 1'b1, ST_REQ_DONE}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, deliver_enable at its reset value
        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req, dir_rows[i].rx, dir_rows[i].lerr, dir_rows[i].car,
                     dir_rows[i].ridx, dir_rows[i].typed, dir_rows[i].st);
        end

        // random phases, each with its own deliver_enable
        for (ph = 0; ph < 8; ph++) begin
            drain();
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            deliver_en = cfg_wr_data;
            src_quiet = (ph == 3);
            sink_quiet = (ph == 5);

            // one packet of the largest size that fits, then reads across it
            if (ph == 2) begin
                send_packet(TYPE_ACL, BUF_BYTES - 1 - HDR_BYTES_ACL, 1'b1);
                send_req(REQ_READ, 8'h00, 1'b0, 1'b1, 10'd1022, 1'b0, ST_WAIT);
                for (k = 0; k < 6; k++) begin
                    send_req(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 10'($urandom_range(512, 1022)),
                             1'b0, ST_WAIT);
                end
            end

            mark = req_sent;
            while (req_sent - mark < 30) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    case ($urandom_range(0, 2))
                        0: kind = TYPE_ACL;
                        1: kind = TYPE_SCO;
                        default: kind = TYPE_EVT;
                    endcase
                    send_packet(kind, $urandom_range(0, 24), 1'b0);
                end else if (r < 70 && hi_water > 0) begin
                    send_req(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 10'($urandom_range(0, hi_water - 1)),
                             1'b0, ST_WAIT);
                end else if (r < 73) begin
                    send_packet(TYPE_ACL, $urandom_range(BUF_BYTES - HDR_BYTES_ACL, 65535), 1'b0);
                end else if (r < 78) begin
                    send_req(REQ_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                             1'b0, ST_WAIT);
                end else if (r < 80) begin
                    send_req(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                             1'b0, ST_WAIT);
                end else if (r < 92) begin
                    send_rx(8'($urandom_range(0, 255)), 1'b0);
                end else begin
                    // byte with any mix of carrier and line error
                    send_req(REQ_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                             1'b0, ST_WAIT);
                end
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (bad_results == 0 && frame_q.size() == 0) begin
            $display("PASS hci_uart_packet_deframer");
        end else begin
            $display("FAIL hci_uart_packet_deframer");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/hcid_pkg.sv
rtl/hcid_buf_mem.sv
rtl/hcid_parser.sv
rtl/hci_uart_packet_deframer.sv
sim/testbench.sv
